// ===== hdl/mspd_pkg.sv =====
// Shared constants, state encoding and control structs for the packet deframer.
package mspd_pkg;

  localparam int DEF_WINDOW_BYTES = 200;
  localparam int DEF_MARKER_COUNT = 4;
  localparam int DEF_MAX_PACKET   = 45;

  localparam int DATA_W = 8;
  localparam int SIZE_W = 6;

  localparam logic [DATA_W-1:0] MARKER_VALUE = 8'hff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_CMP,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic shift;      // write new byte at head, restart marker/byte counters
    logic mark_rd;    // read window at current marker offset
    logic mark_next;  // advance to next marker offset
    logic emit_rd;    // read window at packet byte offset
    logic emit_next;  // advance packet byte counter
    logic out_load;   // load output register from read data
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic disabled;     // packet size above maximum
    logic size_zero;    // empty packet
    logic marker_hit;   // last read byte is a marker
    logic marker_last;  // current marker is the final one
    logic byte_last;    // current packet byte is the final one
    logic out_free;     // output register can take a byte this cycle
  } status_t;

endpackage

// ===== hdl/mspd_ctrl.sv =====
// Controller state machine sequencing window write, marker tests and packet readout.
module mspd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mspd_pkg::status_t status,
  output mspd_pkg::cmd_t    cmd
);

  mspd_pkg::state_t state;
  mspd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mspd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      mspd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        // disabled size: transaction taken and dropped
        if (in_valid && !status.disabled) begin
          cmd.shift  = 1'b1;
          state_next = mspd_pkg::ST_MARK_RD;
        end
      end
      mspd_pkg::ST_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_next  = mspd_pkg::ST_MARK_CMP;
      end
      mspd_pkg::ST_MARK_CMP: begin
        priority if (!status.marker_hit) begin
          state_next = mspd_pkg::ST_IDLE;
        end else if (status.marker_last) begin
          state_next = status.size_zero ? mspd_pkg::ST_IDLE : mspd_pkg::ST_EMIT_RD;
        end else begin
          cmd.mark_next = 1'b1;
          state_next    = mspd_pkg::ST_MARK_RD;
        end
      end
      mspd_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = mspd_pkg::ST_EMIT_WR;
      end
      mspd_pkg::ST_EMIT_WR: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.byte_last) begin
            state_next = mspd_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = mspd_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = mspd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mspd_datapath.sv =====
// Datapath: circular window memory, offset counters, size register and output register.
module mspd_datapath #(
  parameter int WINDOW_BYTES = mspd_pkg::DEF_WINDOW_BYTES,
  parameter int MARKER_COUNT = mspd_pkg::DEF_MARKER_COUNT,
  parameter int MAX_PACKET   = mspd_pkg::DEF_MAX_PACKET
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mspd_pkg::SIZE_W-1:0] cfg_data,
  input  logic [mspd_pkg::DATA_W-1:0] rx_byte,
  input  mspd_pkg::cmd_t              cmd,
  output mspd_pkg::status_t           status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mspd_pkg::DATA_W-1:0] packet_byte,
  output logic [mspd_pkg::SIZE_W-1:0] byte_index,
  output logic                        last_byte
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int FW = $clog2(WINDOW_BYTES + 1);
  localparam int MW = (MARKER_COUNT > 2) ? $clog2(MARKER_COUNT) : 1;
  localparam int SW = mspd_pkg::SIZE_W;
  localparam int DW = mspd_pkg::DATA_W;

  localparam logic [AW:0]   WinSize  = (AW+1)'(WINDOW_BYTES);
  localparam logic [AW-1:0] HeadLast = AW'(WINDOW_BYTES - 1);
  localparam logic [FW-1:0] FillFull = FW'(WINDOW_BYTES);
  localparam logic [MW-1:0] MarkLast = MW'(MARKER_COUNT - 1);
  localparam logic [SW-1:0] SizeMax  = SW'(MAX_PACKET);

  logic [DW-1:0] mem [WINDOW_BYTES];

  logic [SW-1:0] packet_size;
  logic [AW-1:0] head;       // physical address of window position 0
  logic [FW-1:0] fill;       // entries written since reset
  logic [MW-1:0] mark;
  logic [AW-1:0] mark_pos;
  logic [SW-1:0] k;
  logic [DW-1:0] rd_data;
  logic          rd_ok;

  logic [AW-1:0] rd_off;
  logic [AW:0]   addr_sum;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size <= '0;
    end else if (cfg_we) begin
      packet_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.shift) begin
      head <= (head == HeadLast) ? '0 : head + AW'(1);
      if (fill != FillFull) begin
        fill <= fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mark     <= '0;
      mark_pos <= '0;
      k        <= '0;
    end else begin
      if (cmd.mark_next) begin
        mark     <= mark + MW'(1);
        mark_pos <= mark_pos + AW'(packet_size) + AW'(1);
      end
      if (cmd.emit_next) begin
        k <= k + SW'(1);
      end
    end
  end

  // logical offset -> physical address, one wrap at most
  assign rd_en    = cmd.mark_rd || cmd.emit_rd;
  assign rd_off   = cmd.mark_rd ? mark_pos : AW'(k) + AW'(1);
  assign addr_sum = {1'b0, head} + {1'b0, rd_off};
  assign rd_addr  = (addr_sum >= WinSize) ? AW'(addr_sum - WinSize) : addr_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem[head] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (rd_en) begin
      rd_ok <= FW'(rd_addr) < fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      packet_byte <= rd_ok ? rd_data : '0;
      byte_index  <= k;
      last_byte   <= status.byte_last;
    end
  end

  always_comb begin
    status.disabled    = packet_size > SizeMax;
    status.size_zero   = packet_size == '0;
    status.marker_hit  = rd_ok && (rd_data == mspd_pkg::MARKER_VALUE);
    status.marker_last = mark == MarkLast;
    status.byte_last   = ({1'b0, k} + (SW+1)'(1)) == {1'b0, packet_size};
    status.out_free    = !out_valid || !out_stall;
  end

endmodule

// ===== hdl/marker_spaced_packet_deframer.sv =====
// Sequence: accept; each marker test is one window read then one compare, until a miss or
//   the final marker; then each packet byte is a window read then a load into the output reg.
// Throughput: one transaction at a time; no new one is taken until its marker tests and, on
//   a match, its packet readout finish; readout waits while a stall holds the output register.
// Reset: sync, active high; window reads as zeros through a fill count (no clearing pass),
//   packet size returns to 0, output register empties.
module marker_spaced_packet_deframer #(
  parameter int WINDOW_BYTES = mspd_pkg::DEF_WINDOW_BYTES,
  parameter int MARKER_COUNT = mspd_pkg::DEF_MARKER_COUNT,
  parameter int MAX_PACKET   = mspd_pkg::DEF_MAX_PACKET
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: packet size register
  input  logic                        cfg_we,
  input  logic [mspd_pkg::SIZE_W-1:0] cfg_data,
  // received byte stream
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mspd_pkg::DATA_W-1:0] rx_byte,
  // packet byte stream
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mspd_pkg::DATA_W-1:0] packet_byte,
  output logic [mspd_pkg::SIZE_W-1:0] byte_index,
  output logic                        last_byte
);

  // Window is a circular buffer: a transaction overwrites the oldest byte at head
  // and advances head, so logical position i lives at head+i (mod window size).
  mspd_pkg::cmd_t    cmd;
  mspd_pkg::status_t status;

  mspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Output register decouples readout: a new input transaction is taken
  // while the last packet byte still waits downstream.
  mspd_datapath #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .MARKER_COUNT (MARKER_COUNT),
    .MAX_PACKET   (MAX_PACKET)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packet_byte (packet_byte),
    .byte_index  (byte_index),
    .last_byte   (last_byte)
  );

  // window written only on an accepted, enabled transaction
  a_shift_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (in_valid && !in_stall))
    else $error("window shift without input transaction");

  // output register never overwritten while a byte is held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

  // single read port: marker and packet reads never collide
  a_one_read: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mark_rd && cmd.emit_rd))
    else $error("two window reads in one cycle");

  // a loaded byte is presented in the following cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded byte not presented");

endmodule
